@@ src/dcwc_pkg.sv @@
// ---------------------------------------------------------------------------
// DCTCP window controller package
// Shared widths, register indexes, the queued word type and sequence helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package dcwc_pkg;

    localparam int SEQ_W       = 32;
    localparam int SEG_W       = 16;
    localparam int SHIFT_W     = 4;
    localparam int ALPHA_W     = 11;
    localparam int PROD_W      = SEQ_W + ALPHA_W;
    localparam int NUM_W       = SEQ_W + 10;
    localparam int QUOT_W      = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = SEG_W;

    // Alpha is a fraction of 1024; the cut scales by 2^-11
    localparam logic [ALPHA_W-1:0] ALPHA_ONE        = 11'd1024;
    localparam int                 ALPHA_FRAC_BITS  = 11;
    localparam logic [SHIFT_W-1:0] ALPHA_SCALE_BITS = 4'd10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_SHIFT  = 1'b1;

    localparam logic [SEG_W-1:0]   SEG_RESET   = 16'd536;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd4;

    localparam int DCWC_QUEUE_DEPTH = 4;

    // One classified segment waiting for the back end
    typedef struct packed {
        logic             ack_valid;
        logic             ece;
        logic [SEQ_W-1:0] ack_number;
        logic [SEQ_W-1:0] next_send_seq;
        logic [SEQ_W-1:0] cwnd;
        logic [SEQ_W-1:0] acked;
    } t_cmd;

    // Head of the command queue as seen by the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qhead;

    // Wrap-aware: a is before b when a - b is negative
    function automatic logic seq_before(input logic [SEQ_W-1:0] a,
                                        input logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] diff;
        diff = a - b;
        return diff[SEQ_W-1];
    endfunction

    // Saturating 32-bit add
    function automatic logic [SEQ_W-1:0] sat_add(input logic [SEQ_W-1:0] a,
                                                 input logic [SEQ_W-1:0] b);
        logic [SEQ_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[SEQ_W] ? {SEQ_W{1'b1}} : sum[SEQ_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ src/dcwc_front.sv @@
// ---------------------------------------------------------------------------
// DCTCP window controller front end
// Accepts segments, works out the acked byte count and queues the word.
// ---------------------------------------------------------------------------
`default_nettype none

module dcwc_front import dcwc_pkg::*; #(
    parameter int QUEUE_DEPTH = DCWC_QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    output logic                  o_full,
    input  wire logic             i_ack_valid,
    input  wire logic             i_ece_flag,
    input  wire logic [SEQ_W-1:0] i_ack_number,
    input  wire logic [SEQ_W-1:0] i_buffer_head,
    input  wire logic [SEQ_W-1:0] i_next_send_seq,
    input  wire logic [SEQ_W-1:0] i_cwnd_in,
    input  wire logic [SEG_W-1:0] i_segment_size,
    input  wire logic             i_deq,
    output t_qhead                o_head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [SEQ_W-1:0] acked;
    logic             enq;
    logic             deq;
    t_cmd             cmd;

    // Classify the acknowledgement: duplicate, advance or nothing
    always_comb begin
        acked = '0;
        if (i_ack_number == i_buffer_head) begin
            if (seq_before(i_ack_number, i_next_send_seq)) begin
                acked = {{(SEQ_W-SEG_W){1'b0}}, i_segment_size};
            end
        end else if (seq_before(i_buffer_head, i_ack_number)) begin
            acked = i_ack_number - i_buffer_head;
        end
    end

    always_comb begin
        cmd.ack_valid     = i_ack_valid;
        cmd.ece           = i_ece_flag;
        cmd.ack_number    = i_ack_number;
        cmd.next_send_seq = i_next_send_seq;
        cmd.cwnd          = i_cwnd_in;
        cmd.acked         = acked;
    end

    assign o_full = (r_count == CNT_W'(QUEUE_DEPTH));
    assign enq    = i_push && !o_full;
    assign deq    = i_deq && (r_count != '0);

    // Store the classified word
    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_mem[r_wr_ptr] <= cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (enq) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (deq) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (enq && !deq) begin
                r_count <= r_count + 1'b1;
            end else if (deq && !enq) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

@@ src/dcwc_div.sv @@
// ---------------------------------------------------------------------------
// DCTCP window controller divider
// Restoring division, one quotient bit per cycle, eleven quotient bits.
// ---------------------------------------------------------------------------
`default_nettype none

module dcwc_div import dcwc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [SEQ_W-1:0]  i_den,
    output logic                   o_done,
    output logic [QUOT_W-1:0]      o_quot
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [SEQ_W-1:0]  r_rem;
    logic [SEQ_W-1:0]  r_den;
    logic [QUOT_W-1:0] r_num_lo;
    logic [QUOT_W-1:0] r_quot;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [SEQ_W:0]    trial;
    logic              q_bit;
    logic [SEQ_W:0]    n_rem;

    // Shift in the next numerator bit and try the subtract
    always_comb begin
        trial = {r_rem, r_num_lo[QUOT_W-1]};
        q_bit = (trial >= {1'b0, r_den});
        n_rem = q_bit ? (trial - {1'b0, r_den}) : trial;
    end

    // The numerator never reaches den * 2^11, so the upper part seeds the remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem    <= SEQ_W'(i_num[NUM_W-1:QUOT_W]);
            r_num_lo <= i_num[QUOT_W-1:0];
            r_den    <= i_den;
            r_quot   <= '0;
        end else if (r_busy) begin
            r_rem    <= n_rem[SEQ_W-1:0];
            r_num_lo <= {r_num_lo[QUOT_W-2:0], 1'b0};
            r_quot   <= {r_quot[QUOT_W-2:0], q_bit};
        end
    end

    // Count iterations and flag completion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

@@ src/dcwc_back.sv @@
// ---------------------------------------------------------------------------
// DCTCP window controller back end
// Cuts the window, keeps byte counters and alpha, holds the result word.
// ---------------------------------------------------------------------------
`default_nettype none

module dcwc_back import dcwc_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  t_qhead                  i_head,
    output logic                    o_deq,
    input  wire logic [SEG_W-1:0]   i_segment_size,
    input  wire logic [SHIFT_W-1:0] i_alpha_shift,
    output logic                    o_empty,
    input  wire logic               i_pop,
    output logic [SEQ_W-1:0]        o_cwnd_out,
    output logic [SEQ_W-1:0]        o_ssthresh_out,
    output logic                    o_window_cut,
    output logic [ALPHA_W-1:0]      o_alpha_out,
    output logic                    o_alpha_updated
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CUT  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_OUT  = 3'd3;

    logic [2:0]         r_state;
    t_cmd               r_cmd;
    logic [PROD_W-1:0]  r_prod;
    logic               r_reach;
    logic [SEQ_W-1:0]   r_cwnd_res;
    logic               r_updated;
    logic [ALPHA_W-1:0] r_alpha;
    logic [SEQ_W-1:0]   r_ecn;
    logic [SEQ_W-1:0]   r_total;
    logic [SEQ_W-1:0]   r_wend;
    logic               r_out_valid;
    logic [SEQ_W-1:0]   r_o_cwnd;
    logic [SEQ_W-1:0]   r_o_ssth;
    logic               r_o_cut;
    logic [ALPHA_W-1:0] r_o_alpha;
    logic               r_o_updated;

    logic [ALPHA_W-1:0] alpha_scale;
    logic [SEQ_W-1:0]   n_ecn;
    logic [SEQ_W-1:0]   n_total;
    logic [SEQ_W-1:0]   cand;
    logic [SEQ_W-1:0]   floor_w;
    logic [SHIFT_W-1:0] g;
    logic [SHIFT_W-1:0] num_shift;
    logic [NUM_W-1:0]   div_num;
    logic [SEQ_W-1:0]   div_den;
    logic               div_start;
    logic               div_done;
    logic [QUOT_W-1:0]  div_quot;
    logic [ALPHA_W:0]   n_alpha_wide;
    logic [ALPHA_W-1:0] n_alpha;
    logic               out_free;

    assign out_free    = !r_out_valid || i_pop;
    assign alpha_scale = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;

    // Counter updates for the word at the queue head
    always_comb begin
        n_ecn   = r_ecn;
        n_total = r_total;
        if (i_head.cmd.ack_valid) begin
            if (i_head.cmd.ece) begin
                n_ecn = sat_add(r_ecn, i_head.cmd.acked);
            end
            n_total = sat_add(r_total, i_head.cmd.acked);
        end
    end

    // Window cut candidate and floor
    assign cand    = r_cmd.cwnd - r_prod[PROD_W-1:ALPHA_FRAC_BITS];
    assign floor_w = {{(SEQ_W-SEG_W-1){1'b0}}, i_segment_size, 1'b0};

    // Divider operands from the updated counters
    assign g         = (i_alpha_shift > ALPHA_SCALE_BITS) ? ALPHA_SCALE_BITS : i_alpha_shift;
    assign num_shift = ALPHA_SCALE_BITS - g;
    assign div_num   = {{(NUM_W-SEQ_W){1'b0}}, r_ecn} << num_shift;
    assign div_den   = (r_total == '0) ? SEQ_W'(1) : r_total;
    assign div_start = (r_state == ST_CUT) && r_reach;

    // New alpha: decay plus the marked fraction, capped at one
    always_comb begin
        n_alpha_wide = {1'b0, r_alpha} - {1'b0, r_alpha >> g}
                     + {{(ALPHA_W+1-QUOT_W){1'b0}}, div_quot};
        n_alpha      = (n_alpha_wide > {1'b0, ALPHA_ONE}) ? ALPHA_ONE
                                                          : n_alpha_wide[ALPHA_W-1:0];
    end

    dcwc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_deq = (r_state == ST_IDLE) && i_head.valid;

    // Per-word datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    r_cmd     <= i_head.cmd;
                    r_prod    <= PROD_W'(i_head.cmd.cwnd) * PROD_W'(alpha_scale);
                    r_reach   <= i_head.cmd.ack_valid
                                 && !seq_before(i_head.cmd.ack_number, r_wend);
                    r_updated <= 1'b0;
                end
            end
            ST_CUT: begin
                if (r_cmd.ece) begin
                    r_cwnd_res <= (cand > floor_w) ? cand : floor_w;
                end else begin
                    r_cwnd_res <= r_cmd.cwnd;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    r_updated <= 1'b1;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    r_o_cwnd    <= r_cwnd_res;
                    r_o_ssth    <= r_cmd.ece ? r_cwnd_res : '0;
                    r_o_cut     <= r_cmd.ece;
                    r_o_alpha   <= r_alpha;
                    r_o_updated <= r_updated;
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer, estimator state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_alpha     <= '0;
            r_ecn       <= '0;
            r_total     <= '0;
            r_wend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Load a new result word, or drop the one just popped
            if ((r_state == ST_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_head.valid) begin
                        r_ecn   <= n_ecn;
                        r_total <= n_total;
                        r_state <= ST_CUT;
                    end
                end
                ST_CUT: begin
                    r_state <= r_reach ? ST_DIV : ST_OUT;
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_alpha <= n_alpha;
                        r_ecn   <= '0;
                        r_total <= '0;
                        r_wend  <= r_cmd.next_send_seq;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_empty         = !r_out_valid;
    assign o_cwnd_out      = r_o_cwnd;
    assign o_ssthresh_out  = r_o_ssth;
    assign o_window_cut    = r_o_cut;
    assign o_alpha_out     = r_o_alpha;
    assign o_alpha_updated = r_o_updated;

endmodule

`default_nettype wire

@@ src/dctcp_window_controller.sv @@
// ---------------------------------------------------------------------------
// DCTCP window controller
// Alpha estimation over observation windows and ECN window reduction.
//
//   Channel   Handshake       Payload
//   input     push / full     i_ack_valid .. i_cwnd_in
//   result    pop / empty     o_cwnd_out .. o_alpha_updated
//   config    i_cfg_we        i_cfg_index, i_cfg_data (no wait, no read-back)
//
// A word passes the back-end states idle, cut and out when its ACK does not close the
// observation window, and also div when it does: the divider retires one quotient
// bit per cycle for 11 bits, then reports completion from a register.
// The front end keeps accepting into a small command queue meanwhile.
// Reset is synchronous, active low; it clears alpha, both byte counters,
// the window end, the queue and the result word.
// A result waiting on pop holds the back end; the queue fills behind it.
// ---------------------------------------------------------------------------
`default_nettype none

module dctcp_window_controller import dcwc_pkg::*; #(
    parameter int QUEUE_DEPTH = DCWC_QUEUE_DEPTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic                  i_ack_valid,
    input  wire logic                  i_ece_flag,
    input  wire logic [SEQ_W-1:0]      i_ack_number,
    input  wire logic [SEQ_W-1:0]      i_buffer_head,
    input  wire logic [SEQ_W-1:0]      i_next_send_seq,
    input  wire logic [SEQ_W-1:0]      i_cwnd_in,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [SEQ_W-1:0]           o_cwnd_out,
    output logic [SEQ_W-1:0]           o_ssthresh_out,
    output logic                       o_window_cut,
    output logic [ALPHA_W-1:0]         o_alpha_out,
    output logic                       o_alpha_updated
);

    logic [SEG_W-1:0]   r_segment_size;
    logic [SHIFT_W-1:0] r_alpha_shift;
    t_qhead             head;
    logic               deq;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_segment_size <= SEG_RESET;
            r_alpha_shift  <= SHIFT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SEGMENT_SIZE: r_segment_size <= i_cfg_data;
                CFG_ALPHA_SHIFT:  r_alpha_shift  <= i_cfg_data[SHIFT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    dcwc_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_ack_valid     (i_ack_valid),
        .i_ece_flag      (i_ece_flag),
        .i_ack_number    (i_ack_number),
        .i_buffer_head   (i_buffer_head),
        .i_next_send_seq (i_next_send_seq),
        .i_cwnd_in       (i_cwnd_in),
        .i_segment_size  (r_segment_size),
        .i_deq           (deq),
        .o_head          (head)
    );

    dcwc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .o_deq           (deq),
        .i_segment_size  (r_segment_size),
        .i_alpha_shift   (r_alpha_shift),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_cwnd_out      (o_cwnd_out),
        .o_ssthresh_out  (o_ssthresh_out),
        .o_window_cut    (o_window_cut),
        .o_alpha_out     (o_alpha_out),
        .o_alpha_updated (o_alpha_updated)
    );

`ifndef SYNTHESIS
    // Alpha reported with a result never exceeds one
    a_alpha_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_alpha_out <= ALPHA_ONE))
        else $error("alpha above one");

    // Threshold follows the cut window, and is zero without a cut
    a_ssthresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_window_cut ? (o_ssthresh_out == o_cwnd_out)
                                 : (o_ssthresh_out == '0)))
        else $error("ssthresh does not match cut");

    // A cut window never drops below two segments
    a_cut_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_window_cut)
            |-> (o_cwnd_out >= {{(SEQ_W-SEG_W-1){1'b0}}, r_segment_size, 1'b0}))
        else $error("cut window below floor");
`endif

endmodule

`default_nettype wire
